// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
`default_nettype none

package spq_pkg;

   localparam int VALUE_W = 32;
   localparam int PRIO_W  = 16;
   localparam int KIND_W  = 2;
   localparam int ERR_W   = 2;
   localparam int COUNT_W = 5;

   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

   // Operation broadcast to every cell of the chain in the same cycle.
   typedef struct packed {
      logic                     enq;
      logic                     deq;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRIO_W-1:0]  prio;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue: a chain of DEPTH cells kept in descending priority order.
// The response to an accepted request is registered and appears in the cycle after it;
// one request per cycle is taken while the response register is empty or being drained.
// Synchronous active-high reset empties the queue and the response register;
// cell contents are not cleared and are only read below the fill count.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_priority_queue #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata, lowest bit up: data_value[31:0], priority_req[47:32].
   input  wire logic [47:0] req_tdata,
   // tuser: kind[1:0].
   input  wire logic [1:0]  req_tuser,
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata, lowest bit up: head_value[31:0], is_empty[32], entry_count[37:33],
   // error_code[39:38].
   output logic [39:0]      rsp_tdata
);

   localparam int CW = $clog2(DEPTH + 1);

   // Every request is handled across the whole chain at once: an
   // enqueue makes each cell compare its priority with the new one at once,
   // and the cells behind the insertion point take their left neighbor's entry.
   // A dequeue shifts every cell one place toward the head.

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [39:0]   rsp_data_ff, rsp_data_in;

   logic [spq_pkg::KIND_W-1:0]        kind;
   logic signed [spq_pkg::VALUE_W-1:0] req_value;
   logic signed [spq_pkg::PRIO_W-1:0]  req_prio;
   logic                               accept;
   logic                               full, empty;
   logic                               do_enq, do_deq;
   logic [spq_pkg::ERR_W-1:0]          err;
   spq_pkg::cell_ctrl_type             ctrl;

   logic                               bef_chain [DEPTH+1];
   logic signed [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic signed [spq_pkg::PRIO_W-1:0]  cell_prio [DEPTH];
   logic signed [spq_pkg::VALUE_W-1:0] cell_value_in [DEPTH];

   logic signed [spq_pkg::VALUE_W-1:0] head_next;
   logic [CW+4:0]                      count_ext;

   assign kind      = req_tuser;
   assign req_value = req_tdata[31:0];
   assign req_prio  = req_tdata[47:32];

   // A new request is taken only when its response has a free slot, so the
   // queue never changes under a response that is still waiting.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      do_enq = 1'b0;
      do_deq = 1'b0;
      err    = spq_pkg::ERR_NONE;
      case (kind)
         spq_pkg::KIND_ENQUEUE: begin
            if (full) err = spq_pkg::ERR_FULL;
            else      do_enq = accept;
         end
         spq_pkg::KIND_DEQUEUE: begin
            if (empty) err = spq_pkg::ERR_EMPTY;
            else       do_deq = accept;
         end
         default: begin
            // Status reads and the unused code leave the queue as it is.
            err = spq_pkg::ERR_NONE;
         end
      endcase
   end

   assign ctrl.enq   = do_enq;
   assign ctrl.deq   = do_deq;
   assign ctrl.value = req_value;
   assign ctrl.prio  = req_prio;

   assign bef_chain[0] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [spq_pkg::VALUE_W-1:0] left_value, right_value;
      logic signed [spq_pkg::PRIO_W-1:0]  left_prio, right_prio;

      if (i == 0) begin : g_head
         assign left_value = '0;
         assign left_prio  = '0;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign left_prio  = cell_prio[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_value = '0;
         assign right_prio  = '0;
      end else begin : g_body
         assign right_value = cell_value[i+1];
         assign right_prio  = cell_prio[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (CW'(i) < count_ff),
         .prev_ahead  (bef_chain[i]),
         .prev_value  (left_value),
         .prev_prio   (left_prio),
         .next_value  (right_value),
         .next_prio   (right_prio),
         .ahead       (bef_chain[i+1]),
         .value       (cell_value[i]),
         .prio        (cell_prio[i]),
         .value_in    (cell_value_in[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (do_enq)      count_in = count_ff + CW'(1);
      else if (do_deq) count_in = count_ff - CW'(1);
   end

   // The response describes the queue after this request.
   assign head_next = (count_in == '0) ? '0 : cell_value_in[0];
   assign count_ext = {5'd0, count_in};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {err, count_ext[4:0], (count_in == '0), head_next};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
// One entry of the sorted chain: holds a value and its priority.
// Depends on spq_pkg for the broadcast operation struct.
`default_nettype none

module spq_cell (
   input  wire logic                             clock,
   input  wire spq_pkg::cell_ctrl_type           ctrl,
   input  wire logic                             occupied,
   input  wire logic                             prev_ahead,
   input  wire logic signed [spq_pkg::VALUE_W-1:0] prev_value,
   input  wire logic signed [spq_pkg::PRIO_W-1:0]  prev_prio,
   input  wire logic signed [spq_pkg::VALUE_W-1:0] next_value,
   input  wire logic signed [spq_pkg::PRIO_W-1:0]  next_prio,
   output logic                                  ahead,
   output logic signed [spq_pkg::VALUE_W-1:0]    value,
   output logic signed [spq_pkg::PRIO_W-1:0]     prio,
   output logic signed [spq_pkg::VALUE_W-1:0]    value_in
);

   logic signed [spq_pkg::VALUE_W-1:0] value_ff;
   logic signed [spq_pkg::PRIO_W-1:0]  prio_ff;
   logic signed [spq_pkg::PRIO_W-1:0]  prio_in;

   // The new entry belongs ahead of this one when this slot is free or holds a
   // strictly lower priority; equal priorities stay ahead to keep arrival order.
   assign ahead = !occupied || (prio_ff < ctrl.prio);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (ctrl.enq && ahead) begin
         if (prev_ahead) begin
            value_in = prev_value;
            prio_in  = prev_prio;
         end else begin
            value_in = ctrl.value;
            prio_in  = ctrl.prio;
         end
      end else if (ctrl.deq) begin
         value_in = next_value;
         prio_in  = next_prio;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value = value_ff;
   assign prio  = prio_ff;

endmodule

`default_nettype wire

// ===== verif/sorted_priority_queue_tb.sv =====
// Self-checking testbench for sorted_priority_queue: a directed table, then biased random
// traffic. Results come from typed rows or a shadow copy of the sorted queue kept here.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`default_nettype none

module sorted_priority_queue_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;

   // Kind code 3 is not assigned; the block must treat it as a status read.
   localparam logic [spq_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

   localparam int RANDOM_ITEMS  = 1500;
   localparam int STALL_LIMIT   = 1000;
   localparam int HOLD_START    = 1200;
   localparam int HOLD_CYCLES   = 80;
   localparam int REPORT_LIMIT  = 10;
   localparam int DRAIN_CYCLES  = 4;

   // Response fields, packed in the same order as rsp_tdata (highest bits first).
   typedef struct packed {
      logic [spq_pkg::ERR_W-1:0]          err;
      logic [spq_pkg::COUNT_W-1:0]        count;
      logic                               empty;
      logic signed [spq_pkg::VALUE_W-1:0] head;
   } head_report_type;

   // One row of the directed table. A row with typed set carries its own expected
   // response; every other row is checked against the shadow queue.
   typedef struct packed {
      logic [spq_pkg::KIND_W-1:0]         kind;
      logic signed [spq_pkg::VALUE_W-1:0] value;
      logic signed [spq_pkg::PRIO_W-1:0]  prio;
      logic                               typed;
      head_report_type                    report;
   } stim_row_type;

   localparam head_report_type UNTYPED = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // tdata, lowest bit up: data_value[31:0], priority_req[47:32].
   logic [47:0] req_tdata = '0;
   // tuser: kind[1:0].
   logic [1:0]  req_tuser = '0;

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // tdata, lowest bit up: head_value[31:0], is_empty[32], entry_count[37:33],
   // error_code[39:38].
   logic [39:0] rsp_tdata;

   // Side information that travels with the transfer being offered: whether the
   // current row carries a typed-in expectation, and that expectation.
   logic            row_typed  = 1'b0;
   head_report_type row_report = '0;

   // Shadow copy of the queue contents, highest priority at index zero.
   logic signed [spq_pkg::VALUE_W-1:0] shadow_value [DEPTH];
   logic signed [spq_pkg::PRIO_W-1:0]  shadow_prio  [DEPTH];
   int                                 shadow_count = 0;

   head_report_type pending_reports [$];
   int              mismatches     = 0;
   int              stall_cycles   = 0;

   stim_row_type directed_rows [0:24];

   sorted_priority_queue #(
      .DEPTH(DEPTH)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Applies one request to the shadow queue and returns the response it should
   // produce. Enqueue inserts behind every entry of greater or equal priority, so
   // equal priorities keep their arrival order. Errors leave the queue untouched.
   function automatic head_report_type advance_shadow_queue(
      logic [spq_pkg::KIND_W-1:0]         kind,
      logic signed [spq_pkg::VALUE_W-1:0] value,
      logic signed [spq_pkg::PRIO_W-1:0]  prio);
      head_report_type report;
      int              slot;
      report     = '0;
      report.err = spq_pkg::ERR_NONE;
      if (kind == spq_pkg::KIND_ENQUEUE) begin
         if (shadow_count >= DEPTH) begin
            report.err = spq_pkg::ERR_FULL;
         end else begin
            slot = 0;
            while (slot < shadow_count && shadow_prio[slot] >= prio) slot++;
            for (int i = shadow_count; i > slot; i--) begin
               shadow_value[i] = shadow_value[i-1];
               shadow_prio[i]  = shadow_prio[i-1];
            end
            shadow_value[slot] = value;
            shadow_prio[slot]  = prio;
            shadow_count++;
         end
      end else if (kind == spq_pkg::KIND_DEQUEUE) begin
         if (shadow_count == 0) begin
            report.err = spq_pkg::ERR_EMPTY;
         end else begin
            for (int i = 0; i + 1 < shadow_count; i++) begin
               shadow_value[i] = shadow_value[i+1];
               shadow_prio[i]  = shadow_prio[i+1];
            end
            shadow_count--;
         end
      end
      // Status reads and the spare kind code only report the current state.
      report.count = spq_pkg::COUNT_W'(shadow_count);
      report.empty = (shadow_count == 0);
      report.head  = (shadow_count == 0) ? '0 : shadow_value[0];
      return report;
   endfunction

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%0t: mismatch in %s: expected %h, actual %h", $realtime, field,
                     want, got);
      end
   endtask

   // Monitor for both channels. Prediction comes before checking in the same block, so
   // the outcome does not depend on which process wakes first at a clock edge.
   always @(posedge clock) begin : monitor
      head_report_type predicted;
      head_report_type want;
      head_report_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted = advance_shadow_queue(req_tuser, req_tdata[31:0], req_tdata[47:32]);
            pending_reports.push_back(row_typed ? row_report : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: response %h arrived with nothing expected", $realtime,
                           rsp_tdata);
            end else begin
               want = pending_reports.pop_front();
               check_field("head_value", want.head, got.head);
               check_field("is_empty", 32'(want.empty), 32'(got.empty));
               check_field("entry_count", 32'(want.count), 32'(got.count));
               check_field("error_code", 32'(want.err), 32'(got.err));
            end
         end
      end
   end

   // Watchdog: a long run of cycles with no transfer on either side means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("sorted_priority_queue test failed");
            $finish;
         end
      end
   end

   // Response side. It stalls at random, never stalls during one quiet window, and once
   // holds off for a long stretch so that the response register stays full and the block
   // has to stall the request side.
   initial begin : response_sink
      int cycle;
      cycle = 0;
      forever begin
         @(posedge clock);
         cycle++;
         if (cycle == HOLD_START) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= (cycle >= 400 && cycle < 700) || ($urandom_range(99) >= 17);
         end
      end
   end

   // Offers one request and returns at the edge where it is accepted. The valid line
   // is only lowered for idle cycles, so a back-to-back transfer never sees valid
   // lowered and raised in the same time step.
   task automatic send_request(logic [spq_pkg::KIND_W-1:0] kind,
                               logic signed [spq_pkg::VALUE_W-1:0] value,
                               logic signed [spq_pkg::PRIO_W-1:0] prio, logic typed,
                               head_report_type report, bit allow_idle);
      while (allow_idle && $urandom_range(99) < 17) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {prio, value};
      req_tuser  <= kind;
      row_typed  <= typed;
      row_report <= report;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   initial begin : request_source
      int                                enq_bias;
      int                                roll;
      logic [spq_pkg::KIND_W-1:0]        kind;
      logic signed [spq_pkg::PRIO_W-1:0] prio;

      // Directed rows. The first few follow from the empty queue and the extremes;
      // the queue is then filled to its limit and pushed one entry past it.
      directed_rows = '{
         '{spq_pkg::KIND_STATUS,  32'h0000_0000, 16'sh0000, 1'b1,
           '{spq_pkg::ERR_NONE,  5'd0,  1'b1, 32'h0}},
         '{spq_pkg::KIND_DEQUEUE, 32'h0000_0000, 16'sh0000, 1'b1,
           '{spq_pkg::ERR_EMPTY, 5'd0,  1'b1, 32'h0}},
         '{KIND_SPARE,            32'hFFFF_FFFF, 16'shFFFF, 1'b1,
           '{spq_pkg::ERR_NONE,  5'd0,  1'b1, 32'h0}},
         '{spq_pkg::KIND_ENQUEUE, 32'h7FFF_FFFF, 16'sh8000, 1'b1,
           '{spq_pkg::ERR_NONE, 5'd1, 1'b0, 32'h7FFF_FFFF}},
         '{spq_pkg::KIND_ENQUEUE, 32'h8000_0000, 16'sh7FFF, 1'b1,
           '{spq_pkg::ERR_NONE, 5'd2, 1'b0, 32'h8000_0000}},
         // Equal top priority: the newcomer stays behind the older entry.
         '{spq_pkg::KIND_ENQUEUE, 32'hFFFF_FFFF, 16'sh7FFF, 1'b1,
           '{spq_pkg::ERR_NONE, 5'd3, 1'b0, 32'h8000_0000}},
         '{spq_pkg::KIND_DEQUEUE, 32'h0000_0000, 16'sh0000, 1'b1,
           '{spq_pkg::ERR_NONE, 5'd2, 1'b0, 32'hFFFF_FFFF}},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0000, 16'sh8000, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'hAAAA_AAAA, 16'sh0000, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h5555_5555, 16'shFFFF, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0001, 16'sh0001, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0002, 16'sh0000, 1'b0, UNTYPED},
         '{spq_pkg::KIND_STATUS,  32'h1234_5678, 16'sh4321, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0003, 16'sh5555, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0004, 16'shAAAA, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0005, 16'sh0100, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0006, 16'shFF00, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0007, 16'sh0010, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0008, 16'sh8001, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_0009, 16'sh7FFE, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_000A, 16'sh0000, 1'b0, UNTYPED},
         '{spq_pkg::KIND_ENQUEUE, 32'h0000_000B, 16'shC000, 1'b0, UNTYPED},
         // The queue is now full; this enqueue must be refused and change nothing.
         '{spq_pkg::KIND_ENQUEUE, 32'hDEAD_BEEF, 16'sh7FFF, 1'b1,
           '{spq_pkg::ERR_FULL, 5'd16, 1'b0, 32'hFFFF_FFFF}},
         '{KIND_SPARE,            32'h0000_0000, 16'sh0000, 1'b0, UNTYPED},
         '{spq_pkg::KIND_DEQUEUE, 32'h0000_0000, 16'sh0000, 1'b0, UNTYPED}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].prio,
                      directed_rows[i].typed, directed_rows[i].report, 1'b1);

      // Random traffic in bursts. Each burst leans toward filling or draining the
      // queue or is balanced, so both the full and the empty boundaries are crossed many times.
      // Half of the priorities are drawn from a narrow band to force plenty of ties.
      enq_bias = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) begin
            roll = $urandom_range(2);
            enq_bias = (roll == 0) ? 15 : (roll == 1) ? 50 : 85;
         end
         roll = $urandom_range(99);
         if (roll < 8)
            kind = spq_pkg::KIND_STATUS;
         else if (roll < 11)
            kind = KIND_SPARE;
         else if ($urandom_range(99) < enq_bias)
            kind = spq_pkg::KIND_ENQUEUE;
         else
            kind = spq_pkg::KIND_DEQUEUE;
         roll = $urandom_range(9);
         if (roll < 5)
            prio = spq_pkg::PRIO_W'($signed($urandom_range(8)) - 4);
         else if (roll < 8)
            prio = spq_pkg::PRIO_W'($urandom);
         else
            prio = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         // Requests 300 to 499 go out back to back with no idle cycles.
         send_request(kind, $urandom, prio, 1'b0, UNTYPED, !(n >= 300 && n < 500));
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("sorted_priority_queue test passed");
      end else begin
         $display("sorted_priority_queue test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
